FILE: src/qsfp_pkg.sv
package qsfp_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DATA_W    = 32;
    localparam int SWAP_W    = 11;
    localparam int RANGE_W   = 2 * IDX_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_RANGE,
        S_PIV_RD,
        S_PIV_LD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_W1,
        S_SWAP_W2,
        S_FIN_RD,
        S_FIN_W1,
        S_FIN_W2,
        S_PUSH_HI,
        S_PUSH_LO,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic init;
        logic pop;
        logic take_range;
        logic piv_rd;
        logic piv_ld;
        logic scan_rd;
        logic scan_cmp;
        logic swap_w1;
        logic swap_w2;
        logic fin_rd;
        logic fin_w1;
        logic fin_w2;
        logic push_hi;
        logic push_lo;
        logic emit_rd;
        logic emit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic set_end;
        logic small_set;
        logic sp_zero;
        logic skip_range;
        logic past_hi;
        logic less;
        logic emit_last;
    } dp_stat_t;

endpackage

FILE: src/qsfp_ctrl.sv
module qsfp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qsfp_pkg::dp_stat_t stat,
    output qsfp_pkg::dp_cmd_t  cmd,
    output logic               busy
);

    qsfp_pkg::state_t state_reg;
    qsfp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsfp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qsfp_pkg::S_IDLE:
            begin
                if (start && stat.set_end)
                begin
                    state_next = qsfp_pkg::S_INIT;
                end
            end
            qsfp_pkg::S_INIT:
            begin
                state_next = stat.small_set ? qsfp_pkg::S_EMIT_RD : qsfp_pkg::S_POP;
            end
            qsfp_pkg::S_POP:
            begin
                state_next = stat.sp_zero ? qsfp_pkg::S_EMIT_RD : qsfp_pkg::S_RANGE;
            end
            qsfp_pkg::S_RANGE:
            begin
                state_next = stat.skip_range ? qsfp_pkg::S_POP : qsfp_pkg::S_PIV_RD;
            end
            qsfp_pkg::S_PIV_RD:   state_next = qsfp_pkg::S_PIV_LD;
            qsfp_pkg::S_PIV_LD:   state_next = qsfp_pkg::S_SCAN_RD;
            qsfp_pkg::S_SCAN_RD:
            begin
                state_next = stat.past_hi ? qsfp_pkg::S_FIN_RD : qsfp_pkg::S_SCAN_CMP;
            end
            qsfp_pkg::S_SCAN_CMP:
            begin
                state_next = stat.less ? qsfp_pkg::S_SWAP_W1 : qsfp_pkg::S_SCAN_RD;
            end
            qsfp_pkg::S_SWAP_W1:  state_next = qsfp_pkg::S_SWAP_W2;
            qsfp_pkg::S_SWAP_W2:  state_next = qsfp_pkg::S_SCAN_RD;
            qsfp_pkg::S_FIN_RD:   state_next = qsfp_pkg::S_FIN_W1;
            qsfp_pkg::S_FIN_W1:   state_next = qsfp_pkg::S_FIN_W2;
            qsfp_pkg::S_FIN_W2:   state_next = qsfp_pkg::S_PUSH_HI;
            qsfp_pkg::S_PUSH_HI:  state_next = qsfp_pkg::S_PUSH_LO;
            qsfp_pkg::S_PUSH_LO:  state_next = qsfp_pkg::S_POP;
            qsfp_pkg::S_EMIT_RD:  state_next = qsfp_pkg::S_EMIT;
            qsfp_pkg::S_EMIT:
            begin
                if (stat.emit_last)
                begin
                    state_next = qsfp_pkg::S_IDLE;
                end
            end
            default:              state_next = qsfp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            qsfp_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            qsfp_pkg::S_INIT:     cmd.init       = 1'b1;
            qsfp_pkg::S_POP:      cmd.pop        = !stat.sp_zero;
            qsfp_pkg::S_RANGE:    cmd.take_range = !stat.skip_range;
            qsfp_pkg::S_PIV_RD:   cmd.piv_rd     = 1'b1;
            qsfp_pkg::S_PIV_LD:   cmd.piv_ld     = 1'b1;
            qsfp_pkg::S_SCAN_RD:  cmd.scan_rd    = !stat.past_hi;
            qsfp_pkg::S_SCAN_CMP: cmd.scan_cmp   = 1'b1;
            qsfp_pkg::S_SWAP_W1:  cmd.swap_w1    = 1'b1;
            qsfp_pkg::S_SWAP_W2:  cmd.swap_w2    = 1'b1;
            qsfp_pkg::S_FIN_RD:   cmd.fin_rd     = 1'b1;
            qsfp_pkg::S_FIN_W1:   cmd.fin_w1     = 1'b1;
            qsfp_pkg::S_FIN_W2:   cmd.fin_w2     = 1'b1;
            qsfp_pkg::S_PUSH_HI:  cmd.push_hi    = 1'b1;
            qsfp_pkg::S_PUSH_LO:  cmd.push_lo    = 1'b1;
            qsfp_pkg::S_EMIT_RD:  cmd.emit_rd    = 1'b1;
            qsfp_pkg::S_EMIT:     cmd.emit       = 1'b1;
            default:              cmd            = '0;
        endcase
    end

endmodule

FILE: src/qsfp_dp.sv
module qsfp_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [qsfp_pkg::DATA_W-1:0]  value,
    input  logic                                last_item,
    input  qsfp_pkg::dp_cmd_t                   cmd,
    output qsfp_pkg::dp_stat_t                  stat,
    output logic                                strobe,
    output logic signed [qsfp_pkg::DATA_W-1:0]  sorted_value,
    output logic                                last_out,
    output logic        [qsfp_pkg::SWAP_W-1:0]  swap_count
);

    localparam int IW = qsfp_pkg::IDX_W;
    localparam int CW = qsfp_pkg::CNT_W;
    localparam int DW = qsfp_pkg::DATA_W;
    localparam int SW = qsfp_pkg::SWAP_W;
    localparam int RW = qsfp_pkg::RANGE_W;

    logic [DW-1:0] store_mem [qsfp_pkg::MAX_ITEMS];
    logic [RW-1:0] stack_mem [qsfp_pkg::MAX_ITEMS];

    logic [DW-1:0] rdata_reg;
    logic [RW-1:0] sdata_reg;

    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [CW-1:0] sp_reg,    sp_next;
    logic [SW-1:0] swap_reg,  swap_next;
    logic [CW-1:0] k_reg,     k_next;
    logic [IW-1:0] lo_reg,    lo_next;
    logic [IW-1:0] hi_reg,    hi_next;
    logic [IW-1:0] mark_reg,  mark_next;
    logic [DW-1:0] pivot_reg, pivot_next;
    logic [DW-1:0] tmp_reg,   tmp_next;

    logic          strobe_reg;
    logic [DW-1:0] out_value_reg;
    logic          out_last_reg;
    logic [SW-1:0] out_swap_reg;

    logic          st_we;
    logic [IW-1:0] st_waddr;
    logic [DW-1:0] st_wdata;
    logic [IW-1:0] st_raddr;

    logic          sk_we;
    logic [IW-1:0] sk_waddr;
    logic [RW-1:0] sk_wdata;

    logic [IW-1:0] s_lo;
    logic [IW-1:0] s_hi;
    logic [IW-1:0] mark_inc;
    logic          push_hi_ok;
    logic          push_lo_ok;

    assign s_lo     = sdata_reg[IW-1:0];
    assign s_hi     = sdata_reg[RW-1:IW];
    assign mark_inc = mark_reg + IW'(1);

    assign push_hi_ok = ({1'b0, mark_reg} + CW'(1)) < {1'b0, hi_reg};
    assign push_lo_ok = ({1'b0, lo_reg} + CW'(1)) < {1'b0, mark_reg};

    always_comb
    begin
        stat.set_end    = last_item || (cnt_reg == CW'(qsfp_pkg::MAX_ITEMS - 1));
        stat.small_set  = cnt_reg < CW'(2);
        stat.sp_zero    = sp_reg == '0;
        stat.skip_range = ({1'b0, s_hi} >= cnt_reg) || (s_lo >= s_hi);
        stat.past_hi    = k_reg > {1'b0, hi_reg};
        stat.less       = $signed(rdata_reg) < $signed(pivot_reg);
        stat.emit_last  = k_reg == cnt_reg;
    end

    // element store ports
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = k_reg[IW-1:0];
        st_wdata = rdata_reg;
        st_raddr = k_reg[IW-1:0];
        if (cmd.load)
        begin
            st_we    = 1'b1;
            st_waddr = cnt_reg[IW-1:0];
            st_wdata = value;
        end
        if (cmd.scan_rd)
        begin
            st_raddr = k_reg[IW-1:0];
        end
        if (cmd.swap_w1)
        begin
            st_we = 1'b1;
        end
        if (cmd.swap_w2)
        begin
            st_we    = 1'b1;
            st_waddr = mark_reg;
            st_wdata = tmp_reg;
        end
        if (cmd.fin_w1)
        begin
            st_we    = 1'b1;
            st_waddr = lo_reg;
        end
        if (cmd.fin_w2)
        begin
            st_we    = 1'b1;
            st_waddr = mark_reg;
            st_wdata = pivot_reg;
        end
        if (cmd.piv_rd)
        begin
            st_raddr = lo_reg;
        end
        if (cmd.scan_cmp)
        begin
            st_raddr = mark_inc;
        end
        if (cmd.fin_rd)
        begin
            st_raddr = mark_reg;
        end
        if (cmd.emit_rd)
        begin
            st_raddr = '0;
        end
    end

    // range stack ports
    always_comb
    begin
        sk_we    = 1'b0;
        sk_waddr = sp_reg[IW-1:0];
        sk_wdata = {hi_reg, mark_inc};
        if (cmd.init)
        begin
            sk_we    = !stat.small_set;
            sk_waddr = '0;
            sk_wdata = {IW'(cnt_reg - CW'(1)), IW'(0)};
        end
        if (cmd.push_hi)
        begin
            sk_we = push_hi_ok;
        end
        if (cmd.push_lo)
        begin
            sk_we    = push_lo_ok;
            sk_wdata = {mark_reg - IW'(1), lo_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        rdata_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            stack_mem[sk_waddr] <= sk_wdata;
        end
        sdata_reg <= stack_mem[sp_next[IW-1:0]];
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        swap_next  = swap_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mark_next  = mark_reg;
        pivot_next = pivot_reg;
        tmp_next   = tmp_reg;
        if (cmd.load)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.init)
        begin
            swap_next = '0;
            sp_next   = stat.small_set ? CW'(0) : CW'(1);
        end
        if (cmd.pop)
        begin
            sp_next = sp_reg - CW'(1);
        end
        if (cmd.take_range)
        begin
            lo_next = s_lo;
            hi_next = s_hi;
        end
        if (cmd.piv_ld)
        begin
            pivot_next = rdata_reg;
            mark_next  = lo_reg;
            k_next     = {1'b0, lo_reg} + CW'(1);
        end
        if (cmd.scan_cmp)
        begin
            tmp_next = rdata_reg;
            if (stat.less)
            begin
                mark_next = mark_inc;
            end
            else
            begin
                k_next = k_reg + CW'(1);
            end
        end
        if (cmd.swap_w2)
        begin
            swap_next = swap_reg + SW'(1);
            k_next    = k_reg + CW'(1);
        end
        if ((cmd.push_hi && push_hi_ok) || (cmd.push_lo && push_lo_ok))
        begin
            sp_next = sp_reg + CW'(1);
        end
        if (cmd.emit_rd)
        begin
            k_next = CW'(1);
        end
        if (cmd.emit)
        begin
            k_next = k_reg + CW'(1);
            if (stat.emit_last)
            begin
                cnt_next  = '0;
                swap_next = '0;
                sp_next   = '0;
            end
        end
    end

    // the stack read address follows sp_next: on a pop the top word is ready next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            sp_reg     <= '0;
            swap_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            sp_reg     <= sp_next;
            swap_reg   <= swap_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mark_reg  <= mark_next;
        pivot_reg <= pivot_next;
        tmp_reg   <= tmp_next;
        if (cmd.emit)
        begin
            out_value_reg <= rdata_reg;
            out_last_reg  <= stat.emit_last;
            out_swap_reg  <= swap_reg;
        end
    end

    assign strobe       = strobe_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = out_last_reg;
    assign swap_count   = out_swap_reg;

endmodule

FILE: src/quicksort_first_pivot.sv
// channel  | handshake             | words
// ---------+-----------------------+----------------------------------------
// input    | start / busy          | value, last_item
// result   | strobe (no back-pres) | sorted_value, last_out, swap_count
//
// Loading takes one word per cycle; busy stays low until the word that ends a set.
// Sorting uses element and range memories, one write and one read port each, with
// registered reads: init, then pops until the stack is empty; each popped range is
// checked, then partitioned (pivot read and load, scan, swaps, placement, pushes).
// Results then come out back to back, one a cycle, after a first read of the store.
// Reset clears the controller and counters only; memories need no clearing pass.
// The receiver cannot stall: every strobe is a delivered word.
module quicksort_first_pivot
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qsfp_pkg::DATA_W-1:0]  value,
    input  logic                                last_item,
    output logic                                strobe,
    output logic signed [qsfp_pkg::DATA_W-1:0]  sorted_value,
    output logic                                last_out,
    output logic        [qsfp_pkg::SWAP_W-1:0]  swap_count
);

    qsfp_pkg::dp_cmd_t  cmd;
    qsfp_pkg::dp_stat_t stat;

    qsfp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    qsfp_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last_item    (last_item),
        .cmd          (cmd),
        .stat         (stat),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .swap_count   (swap_count)
    );

endmodule

FILE: src/qsfp_chk.sv
module qsfp_chk
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                last_item,
    input logic                                strobe,
    input logic                                last_out,
    input logic        [qsfp_pkg::SWAP_W-1:0]  swap_count
);

    // words of one set leave on consecutive cycles
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_out |=> strobe)
        else $error("result burst broken");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_out |=> !strobe)
        else $error("strobe after last word");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_out |-> busy)
        else $error("input open while results pending");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && $past(strobe) |-> swap_count == $past(swap_count))
        else $error("swap count changed within a set");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_item |=> busy)
        else $error("set end did not start a sort");

endmodule

bind quicksort_first_pivot qsfp_chk u_qsfp_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .last_item  (last_item),
    .strobe     (strobe),
    .last_out   (last_out),
    .swap_count (swap_count)
);

FILE: dv/quicksort_first_pivot_tb.sv
`timescale 1ns / 100ps

module quicksort_first_pivot_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_WORDS  = 100;
    localparam int DIR_ROWS    = 20;

    typedef struct {
        logic signed [qsfp_pkg::DATA_W-1:0] val;
        logic                               last;
        logic [qsfp_pkg::SWAP_W-1:0]        swaps;
    } sorted_word_t;

    // typed = single-element set whose result is written out by hand
    typedef struct {
        logic signed [qsfp_pkg::DATA_W-1:0] val;
        logic                               last;
        bit                                 typed;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic signed [qsfp_pkg::DATA_W-1:0] value;
    logic                               last_item;
    logic                               strobe;
    logic signed [qsfp_pkg::DATA_W-1:0] sorted_value;
    logic                               last_out;
    logic [qsfp_pkg::SWAP_W-1:0]        swap_count;

    quicksort_first_pivot uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_item    (last_item),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .swap_count   (swap_count)
    );

    logic signed [qsfp_pkg::DATA_W-1:0] set_store [qsfp_pkg::MAX_ITEMS];
    int                                 set_len;
    sorted_word_t                       pending_words [$];
    int                                 errors;
    int                                 cycles;
    bit                                 idle_on;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{32'sh7fffffff, 1'b1, 1'b1},
        '{32'sh80000000, 1'b1, 1'b1},
        '{32'sh00000000, 1'b1, 1'b1},
        '{32'shffffffff, 1'b1, 1'b1},
        // all equal: nothing moves
        '{32'sh00000005, 1'b0, 1'b0},
        '{32'sh00000005, 1'b0, 1'b0},
        '{32'sh00000005, 1'b1, 1'b0},
        // already ascending
        '{32'sh00000001, 1'b0, 1'b0},
        '{32'sh00000002, 1'b0, 1'b0},
        '{32'sh00000003, 1'b0, 1'b0},
        '{32'sh00000004, 1'b1, 1'b0},
        // descending
        '{32'sh00000004, 1'b0, 1'b0},
        '{32'sh00000003, 1'b0, 1'b0},
        '{32'sh00000002, 1'b0, 1'b0},
        '{32'sh00000001, 1'b1, 1'b0},
        // extremes mixed with signs
        '{32'sh7fffffff, 1'b0, 1'b0},
        '{32'sh80000000, 1'b0, 1'b0},
        '{32'sh00000000, 1'b0, 1'b0},
        '{32'shffffffff, 1'b0, 1'b0},
        '{32'sh00000001, 1'b1, 1'b0}
    };

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // sort the held set in place, first element as pivot, and queue its words
    task automatic sort_and_queue_set();
        int                                 lo_stack [$];
        int                                 hi_stack [$];
        int                                 lo;
        int                                 hi;
        int                                 mark;
        int                                 k;
        int                                 swaps;
        logic signed [qsfp_pkg::DATA_W-1:0] pivot;
        logic signed [qsfp_pkg::DATA_W-1:0] t;
        sorted_word_t                       w;
        swaps = 0;
        if (set_len > 1)
        begin
            lo_stack.push_back(0);
            hi_stack.push_back(set_len - 1);
        end
        while (lo_stack.size() > 0)
        begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            pivot = set_store[lo];
            mark = lo;
            for (k = lo + 1; k <= hi; k++)
            begin
                if (set_store[k] < pivot)
                begin
                    mark++;
                    t = set_store[k];
                    set_store[k] = set_store[mark];
                    set_store[mark] = t;
                    swaps++;
                end
            end
            t = set_store[lo];
            set_store[lo] = set_store[mark];
            set_store[mark] = t;
            if (mark + 1 < hi)
            begin
                lo_stack.push_back(mark + 1);
                hi_stack.push_back(hi);
            end
            if (mark - 1 > lo)
            begin
                lo_stack.push_back(lo);
                hi_stack.push_back(mark - 1);
            end
        end
        for (k = 0; k < set_len; k++)
        begin
            w.val = set_store[k];
            w.last = (k == set_len - 1);
            w.swaps = swaps[qsfp_pkg::SWAP_W-1:0];
            pending_words.push_back(w);
        end
        set_len = 0;
    endtask

    task automatic predict_word(input logic signed [qsfp_pkg::DATA_W-1:0] v, input logic l);
        set_store[set_len] = v;
        set_len++;
        if (l || set_len == qsfp_pkg::MAX_ITEMS)
            sort_and_queue_set();
    endtask

    // drive one word and hold it until the block takes it
    task automatic send_word(input logic signed [qsfp_pkg::DATA_W-1:0] v, input logic l);
        while (idle_on && $urandom_range(0, 99) < 15)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last_item <= l;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic signed [qsfp_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return int'($urandom_range(0, 8)) - 4;
            default: return $urandom();
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quicksort_first_pivot_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && strobe)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: value %0d last %0b swaps %0d", $time,
                         sorted_value, last_out, swap_count);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (sorted_value !== w.val)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d", $time,
                             w.val, sorted_value);
                    errors++;
                end
                if (last_out !== w.last)
                begin
                    $display("%0t: last_out expected %0b actual %0b", $time,
                             w.last, last_out);
                    errors++;
                end
                if (swap_count !== w.swaps)
                begin
                    $display("%0t: swap_count expected %0d actual %0d", $time,
                             w.swaps, swap_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int                                 r;
        int                                 sent;
        int                                 set_no;
        int                                 size;
        int                                 k;
        bit                                 full_done;
        logic                               l;
        logic signed [qsfp_pkg::DATA_W-1:0] v;
        sorted_word_t                       w;
        errors = 0;
        cycles = 0;
        set_len = 0;
        idle_on = 1'b1;
        full_done = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        last_item = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            send_word(dir_rows[r].val, dir_rows[r].last);
            if (dir_rows[r].typed)
            begin
                w.val = dir_rows[r].val;
                w.last = 1'b1;
                w.swaps = '0;
                pending_words.push_back(w);
            end
            else
                predict_word(dir_rows[r].val, dir_rows[r].last);
        end

        sent = 0;
        set_no = 0;
        while (sent < RAND_WORDS)
        begin
            // a stretch of sets with the sender never pausing
            idle_on = !(set_no >= 5 && set_no < 10);
            if (!full_done && sent >= 40)
            begin
                // full store, no mark: the block must close the set itself
                size = qsfp_pkg::MAX_ITEMS;
                full_done = 1'b1;
            end
            else
                size = $urandom_range(1, 12);
            for (k = 0; k < size; k++)
            begin
                v = rand_value();
                l = (size == qsfp_pkg::MAX_ITEMS) ? 1'b0 : (k == size - 1);
                send_word(v, l);
                predict_word(v, l);
                sent++;
            end
            set_no++;
        end
        start <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("quicksort_first_pivot_tb: done, clean");
        else
            $display("quicksort_first_pivot_tb: done, errors");
        $finish;
    end

endmodule

FILE: quicksort_first_pivot.f
src/qsfp_pkg.sv
src/qsfp_ctrl.sv
src/qsfp_dp.sv
src/quicksort_first_pivot.sv
src/qsfp_chk.sv
dv/quicksort_first_pivot_tb.sv
